// ----- sv/alfe_pkg.sv -----
// ----------------------------------------------------------------------------
// alfe_pkg: shared types and constants of the addressable LED frame encoder
// Chain length, position counter widths, command codes and register indexes.
// ----------------------------------------------------------------------------
package alfe_pkg;

	// Chain geometry
	localparam int LED_COUNT    = 64;
	localparam int LED_W        = $clog2(LED_COUNT + 1);
	localparam int ADDR_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int BITS_PER_LED = 24;
	localparam int SLOT_W       = 5;
	localparam int INDEX_W      = 10;
	localparam int COLOR_W      = 24;
	localparam int DUTY_W       = 16;

	// Reset values of the duty registers
	localparam logic [DUTY_W-1:0] ONE_DUTY_RST  = 16'd60;
	localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = 16'd30;

	// Command codes
	typedef enum logic [1:0] {
		MODE_SET   = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_START = 2'd2,
		MODE_TICK  = 2'd3
	} mode_t;

	// Register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ONE_DUTY  = 1'b0,
		REG_ZERO_DUTY = 1'b1
	} reg_idx_t;

endpackage

// ----- sv/addressable_led_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// addressable_led_frame_encoder: duty-word encoder for a chain of LEDs
// Keeps one 24-bit color per LED in a synchronous RAM and turns each tick
// into the next timer compare word of the frame (green, red, blue, MSB first,
// then 24 reset periods with a duty word of zero, the last one flagged).
//
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------
// command  | start / busy           | mode, led_index, color
// result   | result_valid (strobe)  | duty, frame_last
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A tick passes the read stage and then the output register: the RAM read of
// the current LED's color issues at the transfer, the duty word is registered
// in the cycle after, when the strobe goes high for one cycle.
// A fill sweeps the RAM one entry a cycle, all LED_COUNT entries, with busy high.
// After reset the marks are clear and no frame runs; the RAM is not cleared.
// The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
module addressable_led_frame_encoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  alfe_pkg::mode_t                  mode,
	input  logic [alfe_pkg::INDEX_W-1:0]     led_index,
	input  logic [alfe_pkg::COLOR_W-1:0]     color,
	output logic                             result_valid,
	output logic [alfe_pkg::DUTY_W-1:0]      duty,
	output logic                             frame_last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [alfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [alfe_pkg::DUTY_W-1:0]      cfg_data
);
	import alfe_pkg::*;

	// Color RAM and per-LED written marks
	logic [COLOR_W-1:0] mem [LED_COUNT];
	logic [LED_COUNT-1:0] marks_q;

	logic [DUTY_W-1:0] one_duty_q;
	logic [DUTY_W-1:0] zero_duty_q;

	// Frame position as LED counter and slot within the LED
	logic [LED_W-1:0]  led_q;
	logic [SLOT_W-1:0] slot_q;
	logic              active_q;

	// Fill sweep
	logic               fill_busy_q;
	logic [ADDR_W-1:0]  fill_addr_q;
	logic [COLOR_W-1:0] fill_color_q;

	// Tick stage 1
	logic               tick_s1;
	logic               active_s1;
	logic               last_s1;
	logic               inrange_s1;
	logic [ADDR_W-1:0]  led_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [COLOR_W-1:0] rd_data_s1;

	logic               accept;
	logic               set_ok;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [COLOR_W-1:0] mem_wdata;
	logic               pos_last;
	logic [SLOT_W-1:0]  bit_pos;
	logic [DUTY_W-1:0]  duty_next;

	assign busy      = fill_busy_q | tick_s1;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;
	assign set_ok    = ({1'b0, led_index} < (INDEX_W + 1)'(LED_COUNT));
	assign pos_last  = (led_q == LED_W'(LED_COUNT)) && (slot_q == SLOT_W'(BITS_PER_LED - 1));

	// Select the RAM write: fill sweep or a single set
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_addr_q;
		mem_wdata = fill_color_q;
		if (fill_busy_q) begin
			mem_we = 1'b1;
		end else if (accept && mode == MODE_SET && set_ok) begin
			mem_we    = 1'b1;
			mem_waddr = led_index[ADDR_W-1:0];
			mem_wdata = color;
		end
	end

	// RAM: one write port, one registered read of the current LED
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[led_q[ADDR_W-1:0]];
	end

	// Control: registers, marks, frame position, fill sweep, tick stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_duty_q   <= ONE_DUTY_RST;
			zero_duty_q  <= ZERO_DUTY_RST;
			marks_q      <= '0;
			led_q        <= '0;
			slot_q       <= '0;
			active_q     <= 1'b0;
			fill_busy_q  <= 1'b0;
			fill_addr_q  <= '0;
			fill_color_q <= '0;
			tick_s1      <= 1'b0;
			active_s1    <= 1'b0;
			last_s1      <= 1'b0;
			inrange_s1   <= 1'b0;
			led_s1       <= '0;
			slot_s1      <= '0;
			result_valid <= 1'b0;
			duty         <= '0;
			frame_last   <= 1'b0;
		end else begin
			// Config transfer
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ONE_DUTY:  one_duty_q  <= cfg_data;
					REG_ZERO_DUTY: zero_duty_q <= cfg_data;
					default: ;
				endcase
			end

			// Advance the fill sweep
			if (fill_busy_q) begin
				if (fill_addr_q == ADDR_W'(LED_COUNT - 1)) begin
					fill_busy_q <= 1'b0;
				end
				fill_addr_q <= fill_addr_q + 1'b1;
			end

			tick_s1 <= accept && (mode == MODE_TICK);
			if (accept) begin
				case (mode)
					MODE_SET: begin
						if (set_ok) begin
							marks_q[led_index[ADDR_W-1:0]] <= 1'b1;
						end
					end
					MODE_FILL: begin
						fill_busy_q  <= 1'b1;
						fill_addr_q  <= '0;
						fill_color_q <= color;
						marks_q      <= '1;
					end
					MODE_START: begin
						active_q <= 1'b1;
						led_q    <= '0;
						slot_q   <= '0;
					end
					MODE_TICK: begin
						active_s1  <= active_q;
						last_s1    <= active_q & pos_last;
						inrange_s1 <= (led_q < LED_W'(LED_COUNT));
						led_s1     <= led_q[ADDR_W-1:0];
						slot_s1    <= slot_q;
						if (active_q) begin
							if (pos_last) begin
								active_q <= 1'b0;
								led_q    <= '0;
								slot_q   <= '0;
							end else if (slot_q == SLOT_W'(BITS_PER_LED - 1)) begin
								slot_q <= '0;
								led_q  <= led_q + 1'b1;
							end else begin
								slot_q <= slot_q + 1'b1;
							end
						end
					end
					default: ;
				endcase
			end

			// Register the result from the tick stage
			result_valid <= tick_s1;
			if (tick_s1) begin
				duty       <= duty_next;
				frame_last <= last_s1;
			end else begin
				frame_last <= 1'b0;
			end
		end
	end

	// Map the slot to a color bit: green, red, blue, MSB first
	always_comb begin
		if (slot_s1 < SLOT_W'(8)) begin
			bit_pos = SLOT_W'(15) - slot_s1;
		end else if (slot_s1 < SLOT_W'(16)) begin
			bit_pos = SLOT_W'(31) - slot_s1;
		end else begin
			bit_pos = SLOT_W'(23) - slot_s1;
		end
	end

	// Pick the duty word; reset periods and unwritten LEDs give zero
	always_comb begin
		duty_next = '0;
		if (active_s1 && inrange_s1 && marks_q[led_s1]) begin
			duty_next = rd_data_s1[bit_pos] ? one_duty_q : zero_duty_q;
		end
	end

`ifndef SYNTH
	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_s1 |=> result_valid)
		else $error("tick did not produce a result");

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(tick_s1))
		else $error("result without a preceding tick");

	a_last_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		frame_last |-> result_valid)
		else $error("frame_last without result strobe");

	a_no_tick_during_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!(fill_busy_q && tick_s1))
		else $error("tick overlaps fill sweep");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_s1 && last_s1) |-> (!active_q || $past(accept && mode == MODE_START)))
		else $error("frame still active after last period");
`endif

endmodule
